FILE: design/box_blur_3x3_macros.svh
// Assertion macros shared by the box blur checker.
`ifndef BOX_BLUR_3X3_MACROS_SVH
`define BOX_BLUR_3X3_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BB3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bb3_pkg.sv
// Package with the constants, types and helpers of the 3x3 box blur.
package bb3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 12;
  localparam int PIX_W       = 8;
  localparam int FW_W        = 11;
  localparam int FH_W        = 12;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int SUM_W       = 12;
  localparam int PROD_W      = 25;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // ceil(2^16 / 9); exact quotient for every sum of nine 8-bit pixels.
  localparam logic [12:0] DIV9_RECIP = 13'd7282;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       a;
    res_t       b;
  } push_t;

  function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(DIV9_RECIP);
    return prod[23:16];
  endfunction

endpackage

FILE: design/bb3_res_fifo.sv
// Result queue of the box blur: up to two pushes and one pop per cycle.
module bb3_res_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bb3_pkg::push_t               push_i,
  input  logic                         pop_i,
  output bb3_pkg::res_t                head_o,
  output logic                         valid_o,
  output logic [bb3_pkg::FIFO_CNT_W-1:0] count_o
);
  import bb3_pkg::*;

  res_t                  entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_i.n);
    rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(do_pop);
    count_d  = count_q + FIFO_CNT_W'(push_i.n) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      entry_q[wr_ptr_q] <= push_i.a;
    end
    if (push_i.n == 2'd2) begin
      entry_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: design/box_blur_3x3.sv
// Top level of the streaming 3x3 box blur for 8-bit grayscale frames.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  input   | in        | in_valid_i / in_stall_o | pixel_in_i
//  output  | out       | out_valid_o / out_stall_i | pixel_out_o out_row_o out_col_o
//          |           |                        | last_in_step_o
//  config  | in        | cfg_we_i               | cfg_idx_i cfg_data_i
//
// One pixel transaction is taken per clock unless in_stall_o is high; its results pass
// the staging register and an eight-entry queue and leave one per clock unless stalled.
// The last column from row two on and the last row from column two on yield two
// results per pixel, so in the last row the output paces the input once the queue fills.
// Reset clears the counters, the window and the queue, not the line memory.
// in_stall_o follows the queue fill and the staged pixel, not out_stall_i.
module box_blur_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bb3_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bb3_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bb3_pkg::PIX_W-1:0]     pixel_out_o,
  output logic [bb3_pkg::ROW_W-1:0]     out_row_o,
  output logic [bb3_pkg::COL_W-1:0]     out_col_o,
  output logic                          last_in_step_o
);
  import bb3_pkg::*;

  // Configuration registers.
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;

  // Effective frame size after saturation, and the last column and row.
  logic [COL_W:0]  width_eff;
  logic [COL_W:0]  last_col;
  logic [FH_W-1:0] height_eff;
  logic [FH_W-1:0] last_row;

  always_comb begin
    if (int'(frame_width_q) < 3) begin
      width_eff = (COL_W+1)'(3);
    end else if (int'(frame_width_q) > MAX_WIDTH) begin
      width_eff = (COL_W+1)'(MAX_WIDTH);
    end else begin
      width_eff = (COL_W+1)'(frame_width_q);
    end
    last_col = width_eff - (COL_W+1)'(1);
    if (int'(frame_height_q) < 3) begin
      height_eff = FH_W'(3);
    end else begin
      height_eff = frame_height_q;
    end
    last_row = height_eff - FH_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_W'(640);
      frame_height_q <= FH_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Raster position of the next pixel to arrive.
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (int'(col_q) + 1 >= int'(width_eff)) begin
        col_d = '0;
        if (int'(row_q) + 1 >= int'(height_eff)) begin
          row_d = '0;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line memory: each word holds the pixel two rows up in its upper byte and
  // one row up in its lower byte. It is read at the column of the pixel being
  // taken and written back in the following cycle with the shifted pair. A pixel's
  // read and the write of the pixel before it never share a column, since a
  // row is at least three pixels wide, so no forwarding is needed.
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_rd_q;

  // Pipeline stage after the memory read.
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  logic [ROW_W-1:0] s1_row_q;

  logic [PIX_W-1:0] top, mid;
  assign top = mem_rd_q[2*PIX_W-1:PIX_W];
  assign mid = mem_rd_q[PIX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_col_q] <= {mid, s1_pix_q};
    end
    if (in_acc) begin
      mem_rd_q <= line_mem[col_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q <= pixel_in_i;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  // Window of the two previous columns: [0..2] column c-2 top to bottom,
  // [3..5] column c-1.
  logic [PIX_W-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= s1_pix_q;
    end
  end

  // Neighborhood sum and classification of the staged pixel.
  logic [SUM_W-1:0] sum;
  logic             is_interior;
  logic             is_border;
  logic [PIX_W-1:0] mean;
  res_t             res_int, res_bdr;
  push_t            push;

  always_comb begin
    sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(s1_pix_q);
    for (int i = 0; i < 6; i++) begin
      sum = sum + SUM_W'(win_q[i]);
    end
  end

  assign mean = div9(sum);

  assign is_interior = (s1_row_q >= ROW_W'(2)) && (s1_row_q <= last_row) &&
                       (s1_col_q >= COL_W'(2)) && ({1'b0, s1_col_q} <= last_col);
  assign is_border   = (s1_row_q == '0) || (s1_row_q >= last_row) ||
                       (s1_col_q == '0) || ({1'b0, s1_col_q} >= last_col);

  always_comb begin
    res_int.pix  = mean;
    res_int.row  = s1_row_q - ROW_W'(1);
    res_int.col  = s1_col_q - COL_W'(1);
    res_int.last = !is_border;
    res_bdr.pix  = s1_pix_q;
    res_bdr.row  = s1_row_q;
    res_bdr.col  = s1_col_q;
    res_bdr.last = 1'b1;
    push.n = 2'd0;
    push.a = res_int;
    push.b = res_bdr;
    if (s1_valid_q) begin
      if (is_interior && is_border) begin
        push.n = 2'd2;
      end else if (is_interior) begin
        push.n = 2'd1;
      end else if (is_border) begin
        push.n = 2'd1;
        push.a = res_bdr;
      end
    end
  end

  // Result queue.
  res_t                  head;
  logic [FIFO_CNT_W-1:0] fifo_count;

  bb3_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (!out_stall_i),
    .head_o  (head),
    .valid_o (out_valid_o),
    .count_o (fifo_count)
  );

  // Take a pixel only if the queue has room for two results of the staged
  // pixel and two of the new one, counting no pops.
  assign in_stall_o = (int'(fifo_count) + (s1_valid_q ? 2 : 0)) > (FIFO_DEPTH - 2);

  assign pixel_out_o    = head.pix;
  assign out_row_o      = head.row;
  assign out_col_o      = head.col;
  assign last_in_step_o = head.last;

endmodule

FILE: design/bb3_checker.sv
// Port-level checker of the box blur and its bind to the top level.
`include "box_blur_3x3_macros.svh"

module bb3_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [bb3_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [bb3_pkg::CFG_W-1:0]     cfg_data_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [bb3_pkg::PIX_W-1:0]     pixel_in_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bb3_pkg::PIX_W-1:0]     pixel_out_o,
  input logic [bb3_pkg::ROW_W-1:0]     out_row_o,
  input logic [bb3_pkg::COL_W-1:0]     out_col_o,
  input logic                          last_in_step_o
);
  import bb3_pkg::*;

  // A stalled result stays offered and unchanged.
  `BB3_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(pixel_out_o) && $stable(out_row_o) && $stable(out_col_o) && $stable(last_in_step_o), "stalled result changed")

  // Both results of one pixel are queued together, so the second follows at once.
  `BB3_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_in_step_o, out_valid_o, "second result of a pixel missing")

  // A result rises only after a pixel transaction passed the stage and the queue.
  `BB3_ASSERT_NOW(a_rise_after_in, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2), "result without a pixel two cycles before")

endmodule

bind box_blur_3x3 bb3_checker u_bb3_checker (.*);

FILE: dv/tb_box_blur_3x3.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 3x3 box blur with a predictor of the ordered results.
module tb_box_blur_3x3;
  import bb3_pkg::*;

  localparam int          CLK_HALF      = 5;
  localparam int          RESET_CYCLES  = 7;
  // The block shows a result once its pixel has passed the stage and its queue; the
  // settle wait covers the pipeline plus the output queue draining.
  localparam int          SETTLE_CYCLES = 12;
  localparam int          HOLD_CYCLES   = 80;
  localparam int          RANDOM_ITEMS  = 200;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef enum int {
    FILL_NOISE,
    FILL_WHITE,
    FILL_BLACK,
    FILL_EXTREME,
    FILL_RAMP
  } fill_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [PIX_W-1:0]     pixel_in_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PIX_W-1:0]     pixel_out_o;
  logic [ROW_W-1:0]     out_row_o;
  logic [COL_W-1:0]     out_col_o;
  logic                 last_in_step_o;

  box_blur_3x3 dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_in_i     (pixel_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_out_o    (pixel_out_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .last_in_step_o (last_in_step_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Predictor state: two line stores, the two previous window columns, the
  // raster position and its own copy of the frame size registers.
  logic [PIX_W-1:0] upper_line [MAX_WIDTH];
  logic [PIX_W-1:0] middle_line [MAX_WIDTH];
  logic [PIX_W-1:0] win_q [6];
  int unsigned      row_pos    = 0;
  int unsigned      col_pos    = 0;
  logic [FW_W-1:0]  width_reg  = 11'd640;
  logic [FH_W-1:0]  height_reg = 12'd480;

  res_t             filtered_q [$];  // results the block still owes, oldest first
  logic [PIX_W-1:0] frame_px_q [$];  // pixels waiting to be offered
  logic [PIX_W-1:0] ramp_px    = '0;

  logic        in_took     = 1'b0;
  logic        calm        = 1'b0;  // no random pauses on either side during this phase
  int unsigned in_idle     = 0;
  int unsigned stall_run   = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_asked  = 0;
  int unsigned hold_seen   = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_cnt   = 0;

  // The width saturates to 3..MAX_WIDTH and the height to at least 3.
  function automatic int unsigned eff_w(input logic [FW_W-1:0] v);
    if (v < 3) return 3;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  function automatic int unsigned eff_h(input logic [FH_W-1:0] v);
    return (v < 3) ? 3 : v;
  endfunction

  // Mostly no pause, often a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Number of pixels that bring the raster position back to the frame origin.
  // A position past the last column or row (after a shrink) ends that row or frame.
  function automatic int unsigned pixels_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned row_rest;
    w = eff_w(width_reg);
    h = eff_h(height_reg);
    row_rest = (col_pos >= w - 1) ? 1 : w - col_pos;
    return row_rest + ((row_pos >= h - 1) ? 0 : (h - 1 - row_pos) * w);
  endfunction

  // Works out the zero, one or two results caused by one accepted pixel. The
  // interior result for the pixel up and to the left comes before the border
  // pass-through of the pixel itself.
  task automatic filter_pixel(input logic [PIX_W-1:0] pix);
    int unsigned      w;
    int unsigned      h;
    int unsigned      r;
    int unsigned      c;
    int unsigned      sum;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic             on_border;
    res_t             res;
    w = eff_w(width_reg);
    h = eff_h(height_reg);
    r = row_pos;
    c = col_pos;
    top = '0;
    mid = '0;
    if (c < MAX_WIDTH) begin
      top = upper_line[c];
      mid = middle_line[c];
    end
    on_border = (r == 0) || (r >= h - 1) || (c == 0) || (c >= w - 1);
    if (r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1) begin
      sum = top + mid + pix;
      for (int i = 0; i < 6; i++) sum += win_q[i];
      res.pix  = PIX_W'(sum / 9);
      res.row  = ROW_W'(r - 1);
      res.col  = COL_W'(c - 1);
      res.last = !on_border;
      filtered_q.push_back(res);
    end
    if (on_border) begin
      res.pix  = pix;
      res.row  = ROW_W'(r);
      res.col  = COL_W'(c);
      res.last = 1'b1;
      filtered_q.push_back(res);
    end
    // Slide the window one column and move this column up in the line stores.
    win_q[0] = win_q[3];
    win_q[1] = win_q[4];
    win_q[2] = win_q[5];
    win_q[3] = top;
    win_q[4] = mid;
    win_q[5] = pix;
    if (c < MAX_WIDTH) begin
      upper_line[c]  = mid;
      middle_line[c] = pix;
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Output check, register shadowing and prediction share one process so that
  // the order of pushes and pops on the expected queue is fixed.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected result transaction: pixel %0d row %0d col %0d",
                 pixel_out_o, out_row_o, out_col_o);
          mismatches++;
        end else begin
          want = filtered_q.pop_front();
          check_field("pixel_out", want.pix, pixel_out_o);
          check_field("out_row", want.row, out_row_o);
          check_field("out_col", want.col, out_col_o);
          check_field("last_in_step", want.last, last_in_step_o);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_FRAME_WIDTH) width_reg = cfg_data_i[FW_W-1:0];
        else if (cfg_idx_i == REG_FRAME_HEIGHT) height_reg = cfg_data_i[FH_W-1:0];
      end
      if (in_valid_i && !in_stall_o) filter_pixel(pixel_in_i);
    end
    in_took <= rst_ni && in_valid_i && !in_stall_o;
  end

  // Pixel driver: a held transaction stays put until it is taken; after that
  // the next pixel follows a random pause.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (in_idle != 0) begin
        in_valid_i <= 1'b0;
        in_idle--;
      end else if (frame_px_q.size() != 0) begin
        in_valid_i <= 1'b1;
        pixel_in_i <= frame_px_q.pop_front();
        in_idle = calm ? 0 : idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver. A requested hold-off keeps the output stalled long enough
  // for the block's queue to fill and for the stall to reach the pixel input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
    end else if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_run != 0) begin
      stall_run--;
    end else begin
      stall_run = idle_len();
      out_stall_i <= ($urandom_range(0, 99) < 35);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_pixels(input int unsigned count, input fill_e style);
    for (int unsigned i = 0; i < count; i++) begin
      case (style)
        FILL_WHITE: frame_px_q.push_back({PIX_W{1'b1}});
        FILL_BLACK: frame_px_q.push_back({PIX_W{1'b0}});
        FILL_EXTREME: frame_px_q.push_back($urandom_range(0, 1) ? {PIX_W{1'b1}} : {PIX_W{1'b0}});
        FILL_RAMP: begin
          frame_px_q.push_back(ramp_px);
          ramp_px++;
        end
        default: frame_px_q.push_back(PIX_W'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Waits until every pixel is taken and every owed result has come out. A
  // pixel can owe nothing, so a settling wait follows before the block is
  // treated as idle.
  task automatic drain();
    while (frame_px_q.size() != 0 || in_valid_i || filtered_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned random_items;
    int unsigned new_w;
    int unsigned new_h;
    int unsigned count;
    int unsigned roll;
    logic        at_start;
    fill_e       style;
    random_items = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_q[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A few black pixels at the reset size of 640 x 480, then the width drops
    // below its floor mid-row: the next pixel counts as the last column.
    queue_pixels(4, FILL_BLACK);
    drain();
    write_reg(REG_FRAME_WIDTH, 12'd0);
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    queue_pixels(pixels_to_frame_end(), FILL_EXTREME);
    drain();
    // A full 3 x 3 frame of white gives the largest window sum.
    queue_pixels(9, FILL_WHITE);
    drain();

    // Widest row and tallest frame. The width write sets bit 11, which the
    // register has no room for. The receiver holds off for a long stretch
    // while pixels keep coming, so the block's queue fills up.
    write_reg(REG_FRAME_WIDTH, 12'hFFF);
    write_reg(REG_FRAME_HEIGHT, 12'hFFF);
    calm = 1'b1;
    hold_asked++;
    queue_pixels(MAX_WIDTH, FILL_NOISE);
    drain();
    calm = 1'b0;
    // Narrowing inside the frame is safe: every column kept was filled above.
    write_reg(REG_FRAME_WIDTH, 12'd4);
    queue_pixels(20, FILL_NOISE);
    drain();
    // Height drops below the current row, which ends the frame after this row.
    write_reg(REG_FRAME_HEIGHT, 12'd0);
    queue_pixels(pixels_to_frame_end(), FILL_NOISE);
    drain();

    // Random phases: mostly whole frames with random content, some cut short.
    while (random_items < RANDOM_ITEMS) begin
      at_start = (row_pos == 0) && (col_pos == 0);
      new_w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
      // A wider row mid-frame would read line-store columns this frame never filled.
      if ($urandom_range(0, 2) != 0 && (at_start || eff_w(FW_W'(new_w)) <= eff_w(width_reg)))
        write_reg(REG_FRAME_WIDTH, CFG_W'(new_w));
      new_h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
      if ($urandom_range(0, 2) != 0)
        write_reg(REG_FRAME_HEIGHT, CFG_W'(new_h));
      roll = $urandom_range(0, 9);
      if (roll < 6) style = FILL_NOISE;
      else if (roll == 6) style = FILL_WHITE;
      else if (roll == 7) style = FILL_BLACK;
      else if (roll == 8) style = FILL_EXTREME;
      else style = FILL_RAMP;
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7)
        count = pixels_to_frame_end()
              + $urandom_range(0, 2) * eff_w(width_reg) * eff_h(height_reg);
      else
        count = $urandom_range(1, 25);
      queue_pixels(count, style);
      random_items += count;
      drain();
    end

    if (filtered_q.size() != 0) begin
      $error("%0d expected results never came out", filtered_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/bb3_pkg.sv
design/bb3_res_fifo.sv
design/box_blur_3x3.sv
design/bb3_checker.sv
dv/tb_box_blur_3x3.sv
